FILE: rtl/tsvg_pkg.sv
// Shared types, constants and helper functions for the torus strip vertex generator.
// No dependencies; used by every design module of the block.
package tsvg_pkg;

  // Output format and segment limit
  localparam int unsigned FRAC_BITS    = 14;
  localparam int unsigned MAX_SEGMENTS = 256;
  localparam logic [15:0] OUT_LIM      = 16'(1 << FRAC_BITS);

  // Register map (word index = paddr[3:2])
  localparam int unsigned PADDR_W        = 4;
  localparam logic [1:0]  REG_RING_PARAM = 2'd0;
  localparam logic [1:0]  REG_TUBE_PARAM = 2'd1;
  localparam logic [1:0]  REG_RADIUS     = 2'd2;
  localparam logic [6:0]  RADIUS_RESET   = 7'd50;

  // Phase divider: 44-bit dividend, four quotient bits per stage
  localparam int unsigned SEG_W       = 9;
  localparam int unsigned NUM_W       = 44;
  localparam int unsigned DIV_STEP    = 4;
  localparam int unsigned DIV_STAGES  = NUM_W / DIV_STEP;

  // Pipeline depths
  localparam int unsigned TRIG_LAT = 21;
  localparam int unsigned VTX_LAT  = 5;
  localparam int unsigned PIPE_LAT = DIV_STAGES + TRIG_LAT + VTX_LAT;

  // Trig constants
  localparam logic [31:0] PI_Q30   = 32'd3373259426;
  localparam logic [30:0] Q30_ONE  = 31'(1 << 30);
  localparam int unsigned COS_STEPS = 6;
  localparam int unsigned SIN_STEPS = 5;
  localparam int unsigned COS_DIV [COS_STEPS] = '{132, 90, 56, 30, 12, 2};
  localparam int unsigned SIN_DIV [SIN_STEPS] = '{110, 72, 42, 20, 6};
  localparam int unsigned HSTEP_LAT = 3;
  localparam int unsigned LINE_LEN  = COS_STEPS * HSTEP_LAT + 1;

  // Reciprocal of 200 for the tube radius scaling (dividend below 2^37)
  localparam int unsigned RADIUS_DIV = 200;
  localparam logic [29:0] REC200     = 30'((64'd1 << 37) / RADIUS_DIV);

  typedef struct packed {
    logic [NUM_W-1:0] num;   // dividend bits still to shift in, msb first
    logic [SEG_W-1:0] rem;
    logic [31:0]      quo;   // low 32 quotient bits = phase
  } div_t;

  typedef struct packed {
    logic [31:0] x2;
    logic [30:0] x;
    logic [1:0]  quad;
  } trig_line_t;

  typedef struct packed {
    logic signed [31:0] cp;
    logic signed [31:0] sp;
    logic signed [31:0] ct;
    logic signed [31:0] st;
  } trig_set_t;

  typedef struct packed {
    logic [15:0] norm_z;
    logic [15:0] norm_y;
    logic [15:0] norm_x;
    logic [15:0] pos_z;
    logic [15:0] pos_y;
    logic [15:0] pos_x;
  } vtx_t;

  // Four restoring division steps
  function automatic div_t div_step4(div_t x, logic [SEG_W-1:0] d);
    div_t       y;
    logic [SEG_W:0] r;
    y = x;
    for (int b = 0; b < DIV_STEP; b++) begin
      r     = {y.rem, y.num[NUM_W-1]};
      y.num = {y.num[NUM_W-2:0], 1'b0};
      if (r >= {1'b0, d}) begin
        r     = r - {1'b0, d};
        y.quo = {y.quo[30:0], 1'b1};
      end else begin
        y.quo = {y.quo[30:0], 1'b0};
      end
      y.rem = r[SEG_W-1:0];
    end
    return y;
  endfunction

  // Round half away from zero by n bits, saturate to +-2^FRAC_BITS
  function automatic logic [15:0] round_sat(logic signed [63:0] v, int unsigned n);
    logic [63:0] m;
    logic        neg;
    logic [15:0] r;
    neg = v[63];
    m   = neg ? 64'(-v) : 64'(v);
    m   = (m + (64'd1 << (n - 1))) >> n;
    if (m > 64'(OUT_LIM)) m = 64'(OUT_LIM);
    r = m[15:0];
    if (neg) r = 16'(-r);
    return r;
  endfunction

endpackage

FILE: rtl/tsvg_horner_step.sv
// One Horner stage u = 1 - floor(floor(x2*inner/2^30)/DIVISOR), floored at 0 (Q30).
// Three register stages. Uses tsvg_pkg.
module tsvg_horner_step #(
  parameter int unsigned DIVISOR = 2
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] x2_i,
  input  logic [30:0] inner_i,
  output logic [30:0] u_o
);

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIVISOR);

  logic [61:0] prod;
  logic [63:0] rprod;
  logic [31:0] t_a_q, t_b_q, q0_b_q;
  logic [31:0] qd, rem, q;
  logic [30:0] u_d, u_q;

  assign prod  = 62'(x2_i) * 62'(inner_i);
  assign rprod = 64'(t_a_q) * 64'(RECIP);

  // reciprocal estimate is low by at most one
  always_comb begin
    qd  = q0_b_q * 32'(DIVISOR);
    rem = t_b_q - qd;
    q   = q0_b_q + ((rem >= 32'(DIVISOR)) ? 32'd1 : 32'd0);
    u_d = (q >= 32'(tsvg_pkg::Q30_ONE)) ? '0 : 31'(32'(tsvg_pkg::Q30_ONE) - q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_a_q  <= prod[61:30];
      t_b_q  <= t_a_q;
      q0_b_q <= rprod[63:32];
      u_q    <= u_d;
    end
  end

  assign u_o = u_q;

endmodule

FILE: rtl/tsvg_trig.sv
// Sine and cosine of a 32-bit phase (fraction of a turn), signed Q30 results.
// Pipelined over TRIG_LAT stages; uses tsvg_pkg and tsvg_horner_step.
module tsvg_trig (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        phase_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  logic [61:0] xprod, x2prod, sprod;
  logic [30:0] x_q;
  logic [1:0]  quad_q;
  tsvg_pkg::trig_line_t line_q [tsvg_pkg::LINE_LEN];
  logic [30:0] cu [tsvg_pkg::COS_STEPS+1];
  logic [30:0] su [tsvg_pkg::SIN_STEPS+1];
  logic [30:0] sfin_q, sdly_q;
  logic [30:0] sres_q;
  logic signed [31:0] sn_d, cs_d, sn_q, cs_q;
  logic signed [31:0] sv, cv;

  assign xprod  = 62'(phase_i[29:0]) * 62'(tsvg_pkg::PI_Q30);
  assign x2prod = 62'(x_q) * 62'(x_q);
  assign sprod  = 62'(line_q[tsvg_pkg::SIN_STEPS*tsvg_pkg::HSTEP_LAT].x) *
                  62'(su[tsvg_pkg::SIN_STEPS]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q       <= xprod[61:31];
      quad_q    <= phase_i[31:30];
      line_q[0] <= '{x2: x2prod[61:30], x: x_q, quad: quad_q};
      for (int k = 1; k < tsvg_pkg::LINE_LEN; k++) line_q[k] <= line_q[k-1];
      sfin_q    <= sprod[60:30];
      sdly_q    <= sfin_q;
      sres_q    <= sdly_q;
      sn_q      <= sn_d;
      cs_q      <= cs_d;
    end
  end

  assign cu[0] = tsvg_pkg::Q30_ONE;
  assign su[0] = tsvg_pkg::Q30_ONE;

  for (genvar k = 0; k < tsvg_pkg::COS_STEPS; k++) begin : g_cos
    tsvg_horner_step #(.DIVISOR(tsvg_pkg::COS_DIV[k])) u_step (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .x2_i   (line_q[k*tsvg_pkg::HSTEP_LAT].x2),
      .inner_i(cu[k]),
      .u_o    (cu[k+1])
    );
  end

  for (genvar k = 0; k < tsvg_pkg::SIN_STEPS; k++) begin : g_sin
    tsvg_horner_step #(.DIVISOR(tsvg_pkg::SIN_DIV[k])) u_step (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .x2_i   (line_q[k*tsvg_pkg::HSTEP_LAT].x2),
      .inner_i(su[k]),
      .u_o    (su[k+1])
    );
  end

  // quadrant fold
  always_comb begin
    sv = 32'(sres_q);
    cv = 32'(cu[tsvg_pkg::COS_STEPS]);
    unique case (line_q[tsvg_pkg::LINE_LEN-1].quad)
      2'd0: begin sn_d = sv;  cs_d = cv;  end
      2'd1: begin sn_d = cv;  cs_d = -sv; end
      2'd2: begin sn_d = -sv; cs_d = -cv; end
      default: begin sn_d = -cv; cs_d = sv; end
    endcase
  end

  assign sin_o = sn_q;
  assign cos_o = cs_q;

endmodule

FILE: rtl/torus_strip_vertex_generator_top.sv
// Torus triangle-strip vertex generator, top level.
// Throughput: one output word per cycle while the output is not stalled; a cell gives two vertices, or three when its
//   tube index is 0 or equals the tube count, one vertex issued per advancing cycle into the pipeline.
// Reset (rst_ni low, async): pipeline empty, ring/tube params 0, tube radius 50 percent.
// Uses tsvg_pkg, tsvg_trig, tsvg_horner_step.
module torus_strip_vertex_generator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] ring_index, [16:8] tube_index, rest zero
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z (16b each)
  output logic        m_axis_tlast,   // last vertex of the cell
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [tsvg_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned LAT = tsvg_pkg::PIPE_LAT;

  // ---------------- configuration registers ----------------
  logic [7:0] ring_param_q, tube_param_q;
  logic [6:0] radius_q;
  logic       cfg_wr;
  logic [tsvg_pkg::SEG_W-1:0] seg_s, seg_t;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_param_q <= '0;
      tube_param_q <= '0;
      radius_q     <= tsvg_pkg::RADIUS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        tsvg_pkg::REG_RING_PARAM: ring_param_q <= pwdata[7:0];
        tsvg_pkg::REG_TUBE_PARAM: tube_param_q <= pwdata[7:0];
        tsvg_pkg::REG_RADIUS:     radius_q     <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      tsvg_pkg::REG_RING_PARAM: prdata = {24'd0, ring_param_q};
      tsvg_pkg::REG_TUBE_PARAM: prdata = {24'd0, tube_param_q};
      tsvg_pkg::REG_RADIUS:     prdata = {25'd0, radius_q};
      default:                  prdata = '0;
    endcase
  end

  // segment counts, limited to MAX_SEGMENTS
  always_comb begin
    seg_s = 9'(ring_param_q) + 9'd2;
    seg_t = 9'(tube_param_q) + 9'd2;
    if (seg_s > 9'(tsvg_pkg::MAX_SEGMENTS)) seg_s = 9'(tsvg_pkg::MAX_SEGMENTS);
    if (seg_t > 9'(tsvg_pkg::MAX_SEGMENTS)) seg_t = 9'(tsvg_pkg::MAX_SEGMENTS);
  end

  // ---------------- cell hold and vertex issue ----------------
  // A held cell issues one vertex per advancing cycle: (i,j) [twice if j==0],
  // then (i+1,j+1) [twice if j==t]. The next cell loads as the last one issues.
  logic       hold_v_q, hold_v_d;
  logic [1:0] cnt_q, cnt_d;
  logic [7:0] i_q;
  logic [8:0] j_q;
  logic       adv, in_acc, jz, jt, is_b, req_last;
  logic [1:0] last_idx;
  logic [8:0] ki;
  logic [9:0] kj;
  logic       v_q [LAT];
  logic       l_q [LAT];

  assign adv    = !v_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = !hold_v_q || (adv && req_last);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    jz       = (j_q == 9'd0);
    jt       = (j_q == seg_t);
    last_idx = (jz || jt) ? 2'd2 : 2'd1;
    is_b     = jz ? (cnt_q == 2'd2) : (cnt_q != 2'd0);
    req_last = (cnt_q == last_idx);
    ki       = is_b ? 9'(i_q) + 9'd1 : 9'(i_q);
    kj       = is_b ? 10'(j_q) + 10'd1 : 10'(j_q);
    hold_v_d = hold_v_q;
    cnt_d    = cnt_q;
    if (adv && hold_v_q) begin
      if (req_last) begin
        hold_v_d = 1'b0;
        cnt_d    = 2'd0;
      end else begin
        cnt_d = cnt_q + 2'd1;
      end
    end
    if (in_acc) begin
      hold_v_d = 1'b1;
      cnt_d    = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      hold_v_q <= hold_v_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      i_q <= s_axis_tdata[7:0];
      j_q <= s_axis_tdata[16:8];
    end
  end

  // valid and last travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT; k++) v_q[k] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= hold_v_q;
      for (int k = 1; k < LAT; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l_q[0] <= req_last;
      for (int k = 1; k < LAT; k++) l_q[k] <= l_q[k-1];
    end
  end

  // ---------------- phase dividers ----------------
  // phase = low 32 bits of floor((k*2^32 + d/2) / d); the dropped upper quotient
  // bits are k div d, so the angle wraps modulo the count.
  tsvg_pkg::div_t rdiv_q [tsvg_pkg::DIV_STAGES];
  tsvg_pkg::div_t tdiv_q [tsvg_pkg::DIV_STAGES];
  tsvg_pkg::div_t rdiv_in, tdiv_in;

  always_comb begin
    rdiv_in = '{num: {3'd0, ki, 32'(seg_s >> 1)}, rem: '0, quo: '0};
    tdiv_in = '{num: {2'd0, kj, 32'(seg_t >> 1)}, rem: '0, quo: '0};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rdiv_q[0] <= tsvg_pkg::div_step4(rdiv_in, seg_s);
      tdiv_q[0] <= tsvg_pkg::div_step4(tdiv_in, seg_t);
      for (int k = 1; k < tsvg_pkg::DIV_STAGES; k++) begin
        rdiv_q[k] <= tsvg_pkg::div_step4(rdiv_q[k-1], seg_s);
        tdiv_q[k] <= tsvg_pkg::div_step4(tdiv_q[k-1], seg_t);
      end
    end
  end

  // ---------------- sine / cosine ----------------
  logic signed [31:0] sp, cp, st, ct;

  tsvg_trig u_trig_ring (
    .clk_i  (clk_i),
    .en_i   (adv),
    .phase_i(rdiv_q[tsvg_pkg::DIV_STAGES-1].quo),
    .sin_o  (sp),
    .cos_o  (cp)
  );

  tsvg_trig u_trig_tube (
    .clk_i  (clk_i),
    .en_i   (adv),
    .phase_i(tdiv_q[tsvg_pkg::DIV_STAGES-1].quo),
    .sin_o  (st),
    .cos_o  (ct)
  );

  // ---------------- vertex assembly ----------------
  // V0: p*cos th, p*sin th. V1/V2: divide by 200 toward zero. V3: final products.
  // V4: round and saturate to Q1.14 (output register).
  tsvg_pkg::trig_set_t trg_q [3];
  logic signed [7:0]  p;
  logic signed [39:0] pc_q, ps_q;
  logic [36:0]        mc_d, ms_d, mc_q, ms_q;
  logic [66:0]        qc_prod, qs_prod;
  logic [29:0]        q0c_q, q0s_q;
  logic               negc_q, negs_q;
  logic [36:0]        rc, rs;
  logic [29:0]        qc, qs;
  logic signed [31:0] dc_q, ds_q, a;
  logic signed [63:0] px_q, pz_q, nx_q, nz_q;
  logic signed [31:0] py_q, ny_q;
  tsvg_pkg::vtx_t     vtx_d, vtx_q;

  assign p = signed'({1'b0, radius_q});

  always_comb begin
    mc_d    = pc_q[39] ? 37'(-pc_q) : 37'(pc_q);
    ms_d    = ps_q[39] ? 37'(-ps_q) : 37'(ps_q);
    qc_prod = 67'(mc_d) * 67'(tsvg_pkg::REC200);
    qs_prod = 67'(ms_d) * 67'(tsvg_pkg::REC200);
    rc      = mc_q - 37'(q0c_q) * 37'(tsvg_pkg::RADIUS_DIV);
    rs      = ms_q - 37'(q0s_q) * 37'(tsvg_pkg::RADIUS_DIV);
    qc      = q0c_q + ((rc >= 37'(tsvg_pkg::RADIUS_DIV)) ? 30'd1 : 30'd0);
    qs      = q0s_q + ((rs >= 37'(tsvg_pkg::RADIUS_DIV)) ? 30'd1 : 30'd0);
    a       = 32'sh2000_0000 + dc_q;
  end

  always_comb begin
    vtx_d.pos_x = tsvg_pkg::round_sat(px_q, 60 - tsvg_pkg::FRAC_BITS);
    vtx_d.pos_y = tsvg_pkg::round_sat(64'(py_q), 30 - tsvg_pkg::FRAC_BITS);
    vtx_d.pos_z = tsvg_pkg::round_sat(pz_q, 60 - tsvg_pkg::FRAC_BITS);
    if (radius_q == 7'd0) begin
      // zero tube radius: normal forced to zero
      vtx_d.norm_x = '0;
      vtx_d.norm_y = '0;
      vtx_d.norm_z = '0;
    end else begin
      vtx_d.norm_x = tsvg_pkg::round_sat(nx_q, 60 - tsvg_pkg::FRAC_BITS);
      vtx_d.norm_y = tsvg_pkg::round_sat(64'(ny_q), 30 - tsvg_pkg::FRAC_BITS);
      vtx_d.norm_z = tsvg_pkg::round_sat(nz_q, 60 - tsvg_pkg::FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // V0
      trg_q[0] <= '{cp: cp, sp: sp, ct: ct, st: st};
      pc_q     <= 40'(p) * 40'(ct);
      ps_q     <= 40'(p) * 40'(st);
      // V1
      trg_q[1] <= trg_q[0];
      mc_q     <= mc_d;
      ms_q     <= ms_d;
      q0c_q    <= qc_prod[66:37];
      q0s_q    <= qs_prod[66:37];
      negc_q   <= pc_q[39];
      negs_q   <= ps_q[39];
      // V2
      trg_q[2] <= trg_q[1];
      dc_q     <= negc_q ? -signed'(32'(qc)) : signed'(32'(qc));
      ds_q     <= negs_q ? -signed'(32'(qs)) : signed'(32'(qs));
      // V3
      px_q     <= 64'(a) * 64'(trg_q[2].cp);
      pz_q     <= 64'(a) * 64'(trg_q[2].sp);
      nx_q     <= 64'(trg_q[2].ct) * 64'(trg_q[2].cp);
      nz_q     <= 64'(trg_q[2].ct) * 64'(trg_q[2].sp);
      py_q     <= ds_q;
      ny_q     <= trg_q[2].st;
      // V4
      vtx_q    <= vtx_d;
    end
  end

  assign m_axis_tvalid = v_q[LAT-1];
  assign m_axis_tlast  = l_q[LAT-1];
  assign m_axis_tdata  = vtx_q;

endmodule

FILE: rtl/tsvg_checker.sv
// Port-level checker for the torus strip vertex generator, with its bind.
// Sees only the top-level ports; uses no package.
module tsvg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pready
);

  logic [6:0] pend_q;
  logic       in_acc, end_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign end_acc = m_axis_tvalid && m_axis_tready && m_axis_tlast;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pend_q <= '0;
    else pend_q <= pend_q + (in_acc ? 7'd1 : 7'd0) - (end_acc ? 7'd1 : 7'd0);
  end

  // a stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("output word changed under stall");

  // every closing word belongs to an accepted cell
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_acc |-> pend_q != 7'd0)
    else $error("cell closed with no cell in flight");

  // pos_x and norm_x are saturated to +-1.0 in Q1.14
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $signed(m_axis_tdata[15:0]) <= 16'sd16384
      && $signed(m_axis_tdata[15:0]) >= -16'sd16384
      && $signed(m_axis_tdata[63:48]) <= 16'sd16384
      && $signed(m_axis_tdata[63:48]) >= -16'sd16384)
    else $error("output field out of range");

  // the config port never waits
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable |-> pready)
    else $error("config access stalled");

endmodule

bind torus_strip_vertex_generator_top tsvg_checker u_tsvg_checker (.*);

FILE: bench/tb_torus_strip_vertex_generator_top.sv
// Self-checking bench for the torus strip vertex generator: cells in, strip vertices out.
// Depends on tsvg_pkg and torus_strip_vertex_generator_top; the vertex math is predicted here.

// Predicts the strip vertices of each accepted cell and checks the output words in order.
class torus_vertex_board;
  typedef struct {
    logic [15:0] f[6];
    logic        last;
  } vertex_word_t;

  vertex_word_t     pending_q[$];
  logic [7:0]       ring_param;
  logic [7:0]       tube_param;
  logic [6:0]       radius_pct;
  int               errors;
  int               words_seen;
  int               cells_seen;
  int               repeats_seen;
  string            field_name[6] = '{"pos_x", "pos_y", "pos_z", "norm_x", "norm_y", "norm_z"};

  function void reset_regs();
    ring_param = 8'd0;
    tube_param = 8'd0;
    radius_pct = tsvg_pkg::RADIUS_RESET;
  endfunction

  function longint unsigned horner(longint unsigned x2, longint unsigned inner,
                                   longint unsigned d);
    longint unsigned q;
    q = ((x2 * inner) >> 30) / d;
    return (q >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - q;
  endfunction

  // sin/cos of a 32-bit phase, Q30 signed
  function void sincos(longint unsigned ph, output longint sn, output longint cs);
    longint unsigned x, x2, u, v, rest;
    logic [1:0] quad;
    quad = ph[31:30];
    rest = ph & ((64'd1 << 30) - 1);
    x    = (rest * 64'd3373259426) >> 31;
    x2   = (x * x) >> 30;
    u = horner(x2, 64'd1 << 30, 110);
    u = horner(x2, u, 72);
    u = horner(x2, u, 42);
    u = horner(x2, u, 20);
    u = horner(x2, u, 6);
    v = horner(x2, 64'd1 << 30, 132);
    v = horner(x2, v, 90);
    v = horner(x2, v, 56);
    v = horner(x2, v, 30);
    v = horner(x2, v, 12);
    v = horner(x2, v, 2);
    u = (x * u) >> 30;
    case (quad)
      2'd0: begin sn = u;  cs = v;  end
      2'd1: begin sn = v;  cs = -u; end
      2'd2: begin sn = -u; cs = -v; end
      default: begin sn = -v; cs = u; end
    endcase
  endfunction

  function longint unsigned turn_phase(longint unsigned k, longint unsigned d);
    return (((k % d) << 32) + d / 2) / d;
  endfunction

  // round half away from zero, saturate to +-1.0
  function logic [15:0] to_q14(longint v, int n);
    longint unsigned m;
    longint r;
    m = (v < 0) ? -v : v;
    m = (m + (64'd1 << (n - 1))) >> n;
    r = m;
    if (v < 0) r = -r;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function vertex_word_t torus_point(longint unsigned ki, longint unsigned kj,
                                     longint unsigned s, longint unsigned t);
    vertex_word_t w;
    longint sp, cp, st, ct, p, a;
    p = radius_pct;
    sincos(turn_phase(ki, s), sp, cp);
    sincos(turn_phase(kj, t), st, ct);
    a = (64'sd1 << 29) + (p * ct) / 200;
    w.f[0] = to_q14(a * cp, 46);
    w.f[1] = to_q14((p * st) / 200, 16);
    w.f[2] = to_q14(a * sp, 46);
    if (p == 0) begin
      w.f[3] = '0; w.f[4] = '0; w.f[5] = '0;
    end else begin
      w.f[3] = to_q14(ct * cp, 46);
      w.f[4] = to_q14(st, 16);
      w.f[5] = to_q14(ct * sp, 46);
    end
    w.last = 1'b0;
    return w;
  endfunction

  function void note_cell(logic [7:0] ring, logic [8:0] tube);
    longint unsigned s, t;
    vertex_word_t va, vb;
    s = ring_param + 2;
    t = tube_param + 2;
    if (s > tsvg_pkg::MAX_SEGMENTS) s = tsvg_pkg::MAX_SEGMENTS;
    if (t > tsvg_pkg::MAX_SEGMENTS) t = tsvg_pkg::MAX_SEGMENTS;
    va = torus_point(ring, tube, s, t);
    vb = torus_point(ring + 1, tube + 1, s, t);
    pending_q.push_back(va);
    if (tube == 0) begin
      pending_q.push_back(va);
      repeats_seen++;
    end
    if (tube == t) begin
      pending_q.push_back(vb);
      repeats_seen++;
    end
    vb.last = 1'b1;
    pending_q.push_back(vb);
    cells_seen++;
  endfunction

  function void check_word(logic [95:0] data, logic last);
    vertex_word_t w;
    words_seen++;
    if (pending_q.size() == 0) begin
      $error("vertex word with nothing expected: %h", data);
      errors++;
      return;
    end
    w = pending_q.pop_front();
    for (int k = 0; k < 6; k++)
      if (data[16*k +: 16] !== w.f[k]) begin
        $error("%s: expected %0d, got %0d", field_name[k],
               $signed(w.f[k]), $signed(data[16*k +: 16]));
        errors++;
      end
    if (last !== w.last) begin
      $error("last: expected %0b, got %0b", w.last, last);
      errors++;
    end
  endfunction
endclass

module tb_torus_strip_vertex_generator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;   // cycles with no word moving on either stream

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;      // [7:0] ring_index, [16:8] tube_index
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;           // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [tsvg_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  torus_strip_vertex_generator_top uut (.*);

  torus_vertex_board board = new();
  bit steady;          // when set neither side idles
  int idle_cycles;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Monitor: both streams are sampled at the edge, before any NBA lands.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        board.note_cell(s_axis_tdata[7:0], s_axis_tdata[16:8]);
      if (m_axis_tvalid && m_axis_tready)
        board.check_word(m_axis_tdata, m_axis_tlast);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: %0d cycles without a word", idle_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Sink: random stall before each output word, held ready until it moves.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // APB write: setup cycle, then access cycle; pready is tied high.
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= tsvg_pkg::PADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      tsvg_pkg::REG_RING_PARAM: board.ring_param = val[7:0];
      tsvg_pkg::REG_TUBE_PARAM: board.tube_param = val[7:0];
      default:                  board.radius_pct = val[6:0];
    endcase
  endtask

  task automatic set_torus(int rp, int tp, int pct);
    reg_write(tsvg_pkg::REG_RING_PARAM, rp);
    reg_write(tsvg_pkg::REG_TUBE_PARAM, tp);
    reg_write(tsvg_pkg::REG_RADIUS, pct);
  endtask

  // tvalid stays high across back-to-back cells: one NBA per step
  task automatic send_cell(int ring, int tube);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, 9'(tube), 8'(ring)};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Wait out every expected vertex, then the pipeline depth
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (tsvg_pkg::PIPE_LAT + 10) @(posedge clk_i);
  endtask

  // Mostly cells inside the strip, with seams favored; the rest raw noise.
  task automatic random_cells(int n);
    int s, t, r, tb;
    s = (board.ring_param + 2 > tsvg_pkg::MAX_SEGMENTS) ? tsvg_pkg::MAX_SEGMENTS
                                                         : board.ring_param + 2;
    t = (board.tube_param + 2 > tsvg_pkg::MAX_SEGMENTS) ? tsvg_pkg::MAX_SEGMENTS
                                                         : board.tube_param + 2;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 85) begin
        r = $urandom_range(0, s - 1);
        case ($urandom_range(0, 5))
          0:       tb = 0;
          1:       tb = t;
          default: tb = $urandom_range(0, t);
        endcase
      end else begin
        r  = $urandom_range(0, 255);
        tb = $urandom_range(0, 511);
      end
      send_cell(r, tb);
    end
  endtask

  initial begin
    int cfg_ring[6] = '{254, 0, 255, 3, 17, 0};
    int cfg_tube[6] = '{254, 0, 255, 5, 0, 9};
    int cfg_pct[6]  = '{100, 0, 127, 1, 73, 50};

    board.reset_regs();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: two rings, two tubes, radius 0.25; seams and wrap-around
    send_cell(0, 0);
    send_cell(0, 1);
    send_cell(0, 2);
    send_cell(1, 2);
    send_cell(255, 511);
    send_cell(1, 3);
    send_cell(255, 0);
    send_cell(128, 256);
    drain();

    // Largest counts and full radius, then counts past the limit
    set_torus(254, 254, 100);
    send_cell(0, 0);
    send_cell(255, 256);
    send_cell(127, 128);
    send_cell(200, 300);
    drain();
    set_torus(255, 255, 127);  // counts clip to 256, radius over 100 saturates the positions
    send_cell(255, 256);
    send_cell(0, 257);
    send_cell(64, 0);
    drain();
    set_torus(0, 0, 0);        // zero radius zeroes the normal
    send_cell(0, 0);
    send_cell(1, 1);
    send_cell(0, 2);
    send_cell(170, 85);
    drain();

    for (int p = 0; p < 6; p++) begin
      set_torus(cfg_ring[p], cfg_tube[p], cfg_pct[p]);
      steady = (p == 3);
      random_cells(50);
      drain();
    end
    steady = 1'b0;
    set_torus($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 127));
    random_cells(10);
    drain();

    $display("covered %0d cells, %0d vertex words, %0d seam repeats over 11 torus settings",
             board.cells_seen, board.words_seen, board.repeats_seen);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      if (board.pending_q.size() != 0)
        $error("%0d vertex words never arrived", board.pending_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
